>>> rtl/laplacian_3x3_rgb_mirror_assert.svh
// Assertion macros shared by the checker of the Laplacian filter.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LAPLACIAN_3X3_RGB_MIRROR_ASSERT_SVH
`define LAPLACIAN_3X3_RGB_MIRROR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAP3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define LAP3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

>>> rtl/lap3_pkg.sv
// Package of the 3x3 Laplacian filter: payload types, job type and constants.
// No dependencies; imported by every module of the filter but lap3_ram.
`timescale 1ns / 1ps

package lap3_pkg;

	localparam int PIX_BITS  = 24;
	localparam int CH_BITS   = 8;
	localparam int ROW_BITS  = 12;
	localparam int COL_BITS  = 10;
	localparam int FW_BITS   = 11;
	localparam int FH_BITS   = 13;
	localparam int DATA_BITS = 32;
	localparam int PADDR_BITS = 3;

	localparam int RST_FRAME_WIDTH  = 512;
	localparam int RST_FRAME_HEIGHT = 512;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	localparam logic [CH_BITS-1:0] SAT_MAX = 8'd255;

	typedef struct packed {
		logic [CH_BITS-1:0] red_in;
		logic [CH_BITS-1:0] green_in;
		logic [CH_BITS-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CH_BITS-1:0]  red_out;
		logic [CH_BITS-1:0]  green_out;
		logic [CH_BITS-1:0]  blue_out;
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
		logic                last_of_run;
		logic                frame_done;
	} pix_out_t;

	// One queued job: the 3x3 window after the pixel has been shifted in, the
	// position of that pixel and the set of results it causes.
	typedef struct packed {
		logic [2:0][2:0][PIX_BITS-1:0] win;
		logic [ROW_BITS-1:0]           row;
		logic [COL_BITS-1:0]           col;
		logic [3:0]                    has;
		logic                          top;
		logic                          left;
	} job_t;

	// One channel of the kernel: eight times the absolute sum, saturated.
	function automatic logic [CH_BITS-1:0] lap3_chan(
		input logic [CH_BITS-1:0] up,
		input logic [CH_BITS-1:0] dn,
		input logic [CH_BITS-1:0] lt,
		input logic [CH_BITS-1:0] rt,
		input logic [CH_BITS-1:0] ctr
	);
		logic signed [11:0] s;
		logic [11:0]        a;
		logic [CH_BITS-1:0] v;
		s = $signed(12'(up) + 12'(dn) + 12'(lt) + 12'(rt) - (12'(ctr) << 2));
		a = (s < 0) ? $unsigned(-s) : $unsigned(s);
		if (a > 12'd31) begin
			v = SAT_MAX;
		end else begin
			v = {a[4:0], 3'b000};
		end
		return v;
	endfunction

endpackage

>>> rtl/lap3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the line memory of the filter.
`timescale 1ns / 1ps

module lap3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/lap3_front.sv
// Front end of the filter: accepts pixels, keeps the raster position, reads
// and updates the line memory, shifts the window and classifies each pixel.
// Depends on lap3_pkg and lap3_ram.
`timescale 1ns / 1ps

module lap3_front
	import lap3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  pix_in_t                       pix_data,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
	input  logic [$clog2(MAX_HEIGHT)-1:0] hlast,
	input  logic                          restart,
	input  logic [QCNT_BITS-1:0]          q_count,
	output logic                          push,
	output job_t                          push_job
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic                          accept;
	logic [RW-1:0]                 row_q;
	logic [CW-1:0]                 col_q;
	logic                          s1_valid;
	logic [PIX_BITS-1:0]           px_s1;
	logic [RW-1:0]                 row_s1;
	logic [CW-1:0]                 col_s1;
	logic [3:0]                    has_s1;
	logic                          top_s1;
	logic                          left_s1;
	logic [2:0][2:0][PIX_BITS-1:0] win_q;
	logic [2:0][2:0][PIX_BITS-1:0] win_nx;
	logic [2*PIX_BITS-1:0]         line_rd;
	logic                          row_pos;
	logic                          col_pos;
	logic                          last_row;
	logic                          last_col;

	assign pix_ready = (q_count + QCNT_BITS'(s1_valid)) < QCNT_BITS'(QDEPTH);
	assign accept    = pix_valid && pix_ready;

	assign row_pos  = (row_q != '0);
	assign col_pos  = (col_q != '0);
	assign last_row = (row_q == hlast);
	assign last_col = (col_q == wlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= {pix_data.blue_in, pix_data.green_in, pix_data.red_in};
			row_s1  <= row_q;
			col_s1  <= col_q;
			has_s1  <= {last_row && last_col, last_row && col_pos,
				row_pos && last_col, row_pos && col_pos};
			top_s1  <= (row_q == RW'(1));
			left_s1 <= (col_q == CW'(1));
		end
	end

	// Each entry holds the two rows above the current one: upper in the top half.
	lap3_ram #(
		.WIDTH(2 * PIX_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (s1_valid),
		.wr_addr(col_s1),
		.wr_data({line_rd[PIX_BITS-1:0], px_s1}),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(line_rd)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = line_rd[2*PIX_BITS-1:PIX_BITS];
		win_nx[1][2] = line_rd[PIX_BITS-1:0];
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_valid) begin
			win_q <= win_nx;
		end
	end

	assign push = s1_valid && (has_s1 != 4'b0000);

	always_comb begin
		push_job.win  = win_nx;
		push_job.row  = ROW_BITS'(row_s1);
		push_job.col  = COL_BITS'(col_s1);
		push_job.has  = has_s1;
		push_job.top  = top_s1;
		push_job.left = left_s1;
	end

endmodule

>>> rtl/lap3_queue.sv
// Short job queue between the front end and the back end of the filter.
// Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_queue
	import lap3_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  job_t                 push_job,
	input  logic                 pop,
	output logic                 head_valid,
	output job_t                 head,
	output logic [QCNT_BITS-1:0] count
);

	job_t                 slot_q [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head       = slot_q[rptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

endmodule

>>> rtl/lap3_back.sv
// Back end of the filter: takes jobs from the queue, emits their results one
// per cycle while the output is not stalled, through an output register. Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_back
	import lap3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  job_t     head,
	output logic     pop,
	output logic     res_valid,
	input  logic     res_ready,
	output pix_out_t res_data
);

	localparam logic [1:0] KIND_A = 2'd0;
	localparam logic [1:0] KIND_B = 2'd1;
	localparam logic [1:0] KIND_C = 2'd2;
	localparam logic [1:0] KIND_D = 2'd3;

	logic [3:0]          done_q;
	logic [3:0]          remaining;
	logic [3:0]          pick;
	logic [1:0]          kind;
	logic                last_kind;
	logic                load;
	logic                res_valid_q;
	pix_out_t            res_q;
	pix_out_t            res_nx;
	logic [1:0]          ur;
	logic [1:0]          cr;
	logic [1:0]          dr;
	logic [1:0]          lc;
	logic [1:0]          cc;
	logic [1:0]          rc;
	logic [PIX_BITS-1:0] up_px;
	logic [PIX_BITS-1:0] dn_px;
	logic [PIX_BITS-1:0] lt_px;
	logic [PIX_BITS-1:0] rt_px;
	logic [PIX_BITS-1:0] ct_px;
	logic [2:0][CH_BITS-1:0] ch_res;

	always_comb begin
		remaining = head.has & ~done_q;
		priority if (remaining[0]) begin
			kind = KIND_A;
		end else if (remaining[1]) begin
			kind = KIND_B;
		end else if (remaining[2]) begin
			kind = KIND_C;
		end else begin
			kind = KIND_D;
		end
		pick      = 4'b0001 << kind;
		last_kind = ((remaining & ~pick) == 4'b0000);
	end

	// Mirrored borders: the row above the top row and the column left of the
	// first column are both taken from the far side of the window.
	always_comb begin
		ur = head.top ? 2'd2 : 2'd0;
		lc = head.left ? 2'd2 : 2'd0;
		cr = 2'd1;
		dr = 2'd2;
		cc = 2'd1;
		rc = 2'd2;
		res_nx.out_row    = head.row - ROW_BITS'(1);
		res_nx.out_col    = head.col - COL_BITS'(1);
		res_nx.frame_done = 1'b0;
		unique case (kind)
			KIND_A: begin
			end
			KIND_B: begin
				lc = 2'd1;
				cc = 2'd2;
				rc = 2'd1;
				res_nx.out_col = head.col;
			end
			KIND_C: begin
				ur = 2'd1;
				cr = 2'd2;
				dr = 2'd1;
				res_nx.out_row = head.row;
			end
			KIND_D: begin
				ur = 2'd1;
				cr = 2'd2;
				dr = 2'd1;
				lc = 2'd1;
				cc = 2'd2;
				rc = 2'd1;
				res_nx.out_row    = head.row;
				res_nx.out_col    = head.col;
				res_nx.frame_done = 1'b1;
			end
			default: begin
			end
		endcase
		up_px = head.win[ur][cc];
		dn_px = head.win[dr][cc];
		lt_px = head.win[cr][lc];
		rt_px = head.win[cr][rc];
		ct_px = head.win[cr][cc];
		for (int ch = 0; ch < 3; ch++) begin
			ch_res[ch] = lap3_chan(up_px[ch*CH_BITS +: CH_BITS], dn_px[ch*CH_BITS +: CH_BITS],
				lt_px[ch*CH_BITS +: CH_BITS], rt_px[ch*CH_BITS +: CH_BITS],
				ct_px[ch*CH_BITS +: CH_BITS]);
		end
		res_nx.red_out     = ch_res[0];
		res_nx.green_out   = ch_res[1];
		res_nx.blue_out    = ch_res[2];
		res_nx.last_of_run = last_kind;
	end

	assign load = head_valid && (!res_valid_q || res_ready);
	assign pop  = load && last_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			done_q      <= 4'b0000;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				done_q      <= last_kind ? 4'b0000 : (done_q | pick);
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> rtl/laplacian_3x3_rgb_mirror.sv
// Throughput: one pixel per cycle while the job queue has room; a pixel in the last
// column gives one more result, and on the last row each pixel past the first column
// gives two results or more, so the single output register sets the rate.
// Reset: size registers return to 512 by 512, row and column counts to zero;
// the line memory is not cleared.
// Depends on lap3_pkg, lap3_front, lap3_queue and lap3_back.
`timescale 1ns / 1ps

module laplacian_3x3_rgb_mirror
	import lap3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_in_t               pix_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pix_out_t              res_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0]  pwdata,
	output logic [DATA_BITS-1:0]  prdata,
	output logic                  pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [CW-1:0] WLAST_RST =
		CW'(((RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH) - 1);
	localparam logic [RW-1:0] HLAST_RST =
		RW'(((RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT) - 1);

	logic                 cfg_we;
	logic [FW_BITS-1:0]   frame_width_q;
	logic [FH_BITS-1:0]   frame_height_q;
	logic [CW-1:0]        wlast_q;
	logic [RW-1:0]        hlast_q;
	logic [CW-1:0]        wlast_nx;
	logic [RW-1:0]        hlast_nx;
	logic [FW_BITS-1:0]   fw_wr;
	logic [FH_BITS-1:0]   fh_wr;
	logic                 push;
	job_t                 push_job;
	logic                 pop;
	logic                 head_valid;
	job_t                 head;
	logic [QCNT_BITS-1:0] q_count;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign fw_wr  = pwdata[FW_BITS-1:0];
	assign fh_wr  = pwdata[FH_BITS-1:0];

	always_comb begin
		if (fw_wr < FW_BITS'(2)) begin
			wlast_nx = CW'(1);
		end else if (32'(fw_wr) > MAX_WIDTH) begin
			wlast_nx = CW'(MAX_WIDTH - 1);
		end else begin
			wlast_nx = CW'(fw_wr - FW_BITS'(1));
		end
		if (fh_wr < FH_BITS'(2)) begin
			hlast_nx = RW'(1);
		end else if (32'(fh_wr) > MAX_HEIGHT) begin
			hlast_nx = RW'(MAX_HEIGHT - 1);
		end else begin
			hlast_nx = RW'(fh_wr - FH_BITS'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_BITS'(RST_FRAME_WIDTH);
			frame_height_q <= FH_BITS'(RST_FRAME_HEIGHT);
			wlast_q        <= WLAST_RST;
			hlast_q        <= HLAST_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_WIDTH: begin
					frame_width_q <= fw_wr;
					wlast_q       <= wlast_nx;
				end
				REG_HEIGHT: begin
					frame_height_q <= fh_wr;
					hlast_q        <= hlast_nx;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = DATA_BITS'(frame_width_q);
			REG_HEIGHT: prdata = DATA_BITS'(frame_height_q);
			default:    prdata = '0;
		endcase
	end

	lap3_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data (pix_data),
		.wlast    (wlast_q),
		.hlast    (hlast_q),
		.restart  (cfg_we),
		.q_count  (q_count),
		.push     (push),
		.push_job (push_job)
	);

	lap3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.count     (q_count)
	);

	lap3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

>>> rtl/lap3_checker.sv
// Port-level checker of the Laplacian filter and its bind to the top level.
// Depends on lap3_pkg and laplacian_3x3_rgb_mirror_assert.svh.
`timescale 1ns / 1ps
`include "laplacian_3x3_rgb_mirror_assert.svh"

module lap3_checker
	import lap3_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     res_valid,
	input logic     res_ready,
	input pix_out_t res_data
);

	`LAP3_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))
	`LAP3_ASSERT_IMPL(a_done_is_last, clk, arst_n, res_valid && res_data.frame_done, res_data.last_of_run)
	`LAP3_ASSERT_IMPL(a_red_scaled, clk, arst_n, res_valid, (res_data.red_out[2:0] == 3'b000) || (res_data.red_out == SAT_MAX))
	`LAP3_ASSERT_IMPL(a_green_scaled, clk, arst_n, res_valid, (res_data.green_out[2:0] == 3'b000) || (res_data.green_out == SAT_MAX))

endmodule

bind laplacian_3x3_rgb_mirror lap3_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data (res_data)
);

>>> sim/tb_top.sv
// Self-checking testbench of laplacian_3x3_rgb_mirror: result transactions are checked
// against an in-bench prediction of the filter made from the pixel transactions.
// Depends on lap3_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import lap3_pkg::*;

	localparam int     MAX_W         = 1024;
	localparam int     MAX_H         = 4096;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     RANDOM_ITEMS  = 40;
	localparam longint CYCLE_LIMIT   = 200000;

	typedef enum {FILL_UNIFORM, FILL_EXTREME, FILL_FLAT} fill_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_in_t               pix_data  = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	pix_out_t              res_data;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [PADDR_BITS-1:0] paddr     = '0;
	logic [DATA_BITS-1:0]  pwdata    = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	laplacian_3x3_rgb_mirror dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data (pix_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pix_in_t             upper_rows[MAX_W];
	pix_in_t             middle_rows[MAX_W];
	pix_in_t             window[3][3];
	logic [ROW_BITS-1:0] cur_row;
	logic [COL_BITS-1:0] cur_col;
	logic [FW_BITS-1:0]  width_reg;
	logic [FH_BITS-1:0]  height_reg;

	pix_out_t   filtered_queue[$];
	pix_out_t   want;
	int         errors     = 0;
	longint     cycles     = 0;
	int         hold_left  = 0;
	int         ready_idle = 0;
	bit         quiet      = 1'b0;
	int         items_sent = 0;
	logic [7:0] flat_base  = 8'd0;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) begin
			$display("%0t ns mismatch: %s", $time, msg);
		end
	endtask

	function automatic int clamp_size(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [7:0] lap_channel(input logic [7:0] n, input logic [7:0] s,
			input logic [7:0] w, input logic [7:0] e, input logic [7:0] ctr);
		int total;
		int mag;
		total = int'(n) + int'(s) + int'(w) + int'(e) - 4 * int'(ctr);
		mag = (total < 0) ? -total : total;
		return (8 * mag > 255) ? 8'd255 : 8'(8 * mag);
	endfunction

	function automatic pix_out_t filter_at(input int ur, input int cr, input int dr,
			input int lc, input int cc, input int rc, input int row, input int col,
			input logic done);
		pix_out_t o;
		o.red_out = lap_channel(window[ur][cc].red_in, window[dr][cc].red_in,
			window[cr][lc].red_in, window[cr][rc].red_in, window[cr][cc].red_in);
		o.green_out = lap_channel(window[ur][cc].green_in, window[dr][cc].green_in,
			window[cr][lc].green_in, window[cr][rc].green_in, window[cr][cc].green_in);
		o.blue_out = lap_channel(window[ur][cc].blue_in, window[dr][cc].blue_in,
			window[cr][lc].blue_in, window[cr][rc].blue_in, window[cr][cc].blue_in);
		o.out_row = ROW_BITS'(row);
		o.out_col = COL_BITS'(col);
		o.last_of_run = 1'b0;
		o.frame_done = done;
		return o;
	endfunction

	task automatic clear_prediction();
		for (int i = 0; i < MAX_W; i++) begin
			upper_rows[i] = '0;
			middle_rows[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				window[i][j] = '0;
			end
		end
		cur_row = '0;
		cur_col = '0;
		width_reg = FW_BITS'(RST_FRAME_WIDTH);
		height_reg = FH_BITS'(RST_FRAME_HEIGHT);
	endtask

	task automatic predict_pixel(input pix_in_t px);
		int       w;
		int       h;
		int       r;
		int       c;
		int       n;
		int       ur;
		int       lc;
		bit       last_row;
		bit       last_col;
		pix_in_t  up_px;
		pix_in_t  mid_px;
		pix_out_t batch[4];
		w = clamp_size(int'(width_reg), 2, MAX_W);
		h = clamp_size(int'(height_reg), 2, MAX_H);
		r = int'(cur_row);
		c = int'(cur_col);
		last_row = (r == h - 1);
		last_col = (c == w - 1);
		n = 0;
		up_px = upper_rows[c];
		mid_px = middle_rows[c];
		upper_rows[c] = mid_px;
		middle_rows[c] = px;
		for (int i = 0; i < 3; i++) begin
			window[i][0] = window[i][1];
			window[i][1] = window[i][2];
		end
		window[0][2] = up_px;
		window[1][2] = mid_px;
		window[2][2] = px;
		lc = (c == 1) ? 2 : 0;
		if (r >= 1) begin
			ur = (r == 1) ? 2 : 0;
			if (c >= 1) begin
				batch[n] = filter_at(ur, 1, 2, lc, 1, 2, r - 1, c - 1, 1'b0);
				n++;
			end
			if (last_col) begin
				batch[n] = filter_at(ur, 1, 2, 1, 2, 1, r - 1, c, 1'b0);
				n++;
			end
		end
		if (last_row) begin
			if (c >= 1) begin
				batch[n] = filter_at(1, 2, 1, lc, 1, 2, r, c - 1, 1'b0);
				n++;
			end
			if (last_col) begin
				batch[n] = filter_at(1, 2, 1, 1, 2, 1, r, c, 1'b1);
				n++;
			end
		end
		if (n > 0) begin
			batch[n - 1].last_of_run = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			filtered_queue.push_back(batch[i]);
		end
		if (last_col) begin
			cur_col = '0;
			cur_row = last_row ? '0 : ROW_BITS'(r + 1);
		end else begin
			cur_col = COL_BITS'(c + 1);
		end
	endtask

	function automatic pix_in_t gen_pixel(input fill_t mode);
		pix_in_t p;
		case (mode)
			FILL_EXTREME: begin
				p.red_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.blue_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			FILL_FLAT: begin
				p.red_in = flat_base + 8'($urandom_range(0, 4));
				p.green_in = flat_base + 8'($urandom_range(0, 4));
				p.blue_in = flat_base + 8'($urandom_range(0, 4));
			end
			default: begin
				p = pix_in_t'(24'($urandom));
			end
		endcase
		return p;
	endfunction

	task automatic send_pixel(input pix_in_t px);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= px;
		do @(posedge clk); while (!pix_ready);
		predict_pixel(px);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixels(input int count, input fill_t mode);
		for (int i = 0; i < count; i++) begin
			send_pixel(gen_pixel(mode));
		end
	endtask

	task automatic wait_drained();
		pix_valid <= 1'b0;
		while (filtered_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic sel, input logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_BITS'({sel, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_WIDTH) begin
			width_reg = value[FW_BITS-1:0];
		end else begin
			height_reg = value[FH_BITS-1:0];
		end
		cur_row = '0;
		cur_col = '0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_read(input logic sel, output logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_BITS'({sel, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_register(input logic sel, input logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] rd;
		apb_read(sel, rd);
		if (rd !== value) begin
			report_mismatch($sformatf("register %0d reads %0h, want %0h", sel, rd, value));
		end
	endtask

	task automatic configure_frame(input int w, input int h);
		wait_drained();
		apb_write(REG_WIDTH, DATA_BITS'(w));
		apb_write(REG_HEIGHT, DATA_BITS'(h));
	endtask

	task automatic test_register_access();
		check_register(REG_WIDTH, DATA_BITS'(RST_FRAME_WIDTH));
		check_register(REG_HEIGHT, DATA_BITS'(RST_FRAME_HEIGHT));
		apb_write(REG_WIDTH, 32'h7FF);
		check_register(REG_WIDTH, 32'h7FF);
		apb_write(REG_HEIGHT, 32'h1FFF);
		check_register(REG_HEIGHT, 32'h1FFF);
		apb_write(REG_WIDTH, 32'h555);
		check_register(REG_WIDTH, 32'h555);
		apb_write(REG_HEIGHT, 32'hAAA);
		check_register(REG_HEIGHT, 32'hAAA);
		apb_write(REG_WIDTH, 32'h0);
		check_register(REG_WIDTH, 32'h0);
		apb_write(REG_HEIGHT, 32'h0);
		check_register(REG_HEIGHT, 32'h0);
	endtask

	task automatic test_directed_frames();
		pix_in_t px;
		configure_frame(2, 2);
		for (int i = 0; i < 4; i++) begin
			px = (i == 0 || i == 3) ? pix_in_t'({8'hFF, 8'h00, 8'hFF})
				: pix_in_t'({8'h00, 8'hFF, 8'h00});
			send_pixel(px);
		end
		configure_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			px.red_in = 8'(i * 3);
			px.green_in = (i == 4) ? 8'hFF : 8'h00;
			px.blue_in = (i % 2 == 1) ? 8'hFF : 8'h00;
			send_pixel(px);
		end
		configure_frame(4, 2);
		flat_base = 8'd100;
		send_pixels(12, FILL_FLAT);
		wait_drained();
	endtask

	task automatic test_size_extremes();
		configure_frame(0, 1);
		send_pixels(8, FILL_EXTREME);
		configure_frame(1, 0);
		send_pixels(4, FILL_UNIFORM);
		configure_frame(2047, 2);
		send_pixels(24, FILL_UNIFORM);
		configure_frame(2, 8191);
		send_pixels(24, FILL_UNIFORM);
		configure_frame(MAX_W, MAX_H);
		send_pixels(24, FILL_EXTREME);
		configure_frame(3, 4);
		send_pixels(7, FILL_UNIFORM);
		wait_drained();
		apb_write(REG_WIDTH, 32'd3);
		send_pixels(12, FILL_UNIFORM);
		wait_drained();
	endtask

	task automatic test_output_stall();
		configure_frame(4, 3);
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		send_pixels(24, FILL_UNIFORM);
		wait_drained();
	endtask

	task automatic test_input_pause();
		configure_frame(5, 4);
		send_pixels(11, FILL_UNIFORM);
		wait_drained();
		send_pixels(9, FILL_UNIFORM);
		wait_drained();
	endtask

	task automatic test_random_frames();
		int    stop_at;
		int    w;
		int    h;
		int    area;
		int    kind;
		int    part;
		fill_t mode;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 6);
			h = $urandom_range(2, 5);
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 9) == 0) begin
				h = $urandom_range(0, 1);
			end
			area = clamp_size(w, 2, MAX_W) * clamp_size(h, 2, MAX_H);
			mode = fill_t'($urandom_range(0, 2));
			flat_base = 8'($urandom_range(0, 250));
			configure_frame(w, h);
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				send_pixels($urandom_range(1, area - 1), mode);
			end else if (kind == 2) begin
				part = $urandom_range(1, area - 1);
				send_pixels(part, mode);
				wait_drained();
				send_pixels(area - part, mode);
			end else begin
				send_pixels(area * $urandom_range(1, 2), mode);
			end
		end
		wait_drained();
	endtask

	task automatic test_full_rate();
		quiet = 1'b1;
		configure_frame(6, 4);
		send_pixels(24, FILL_UNIFORM);
		configure_frame(3, 2);
		send_pixels(12, FILL_EXTREME);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (ready_idle > 0) begin
			ready_idle--;
			res_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			ready_idle = $urandom_range(0, 15);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (filtered_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result transaction at (%0d,%0d)",
					res_data.out_row, res_data.out_col));
			end else begin
				want = filtered_queue.pop_front();
				if (res_data.red_out !== want.red_out)
					report_mismatch($sformatf("red_out at (%0d,%0d): got %0d, want %0d",
						want.out_row, want.out_col, res_data.red_out, want.red_out));
				if (res_data.green_out !== want.green_out)
					report_mismatch($sformatf("green_out at (%0d,%0d): got %0d, want %0d",
						want.out_row, want.out_col, res_data.green_out, want.green_out));
				if (res_data.blue_out !== want.blue_out)
					report_mismatch($sformatf("blue_out at (%0d,%0d): got %0d, want %0d",
						want.out_row, want.out_col, res_data.blue_out, want.blue_out));
				if (res_data.out_row !== want.out_row)
					report_mismatch($sformatf("out_row: got %0d, want %0d",
						res_data.out_row, want.out_row));
				if (res_data.out_col !== want.out_col)
					report_mismatch($sformatf("out_col: got %0d, want %0d",
						res_data.out_col, want.out_col));
				if (res_data.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run at (%0d,%0d): got %0b, want %0b",
						want.out_row, want.out_col, res_data.last_of_run, want.last_of_run));
				if (res_data.frame_done !== want.frame_done)
					report_mismatch($sformatf("frame_done at (%0d,%0d): got %0b, want %0b",
						want.out_row, want.out_col, res_data.frame_done, want.frame_done));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** laplacian_3x3_rgb_mirror: FAILED **");
			$finish;
		end
	end

	initial begin
		clear_prediction();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_access();
		test_directed_frames();
		test_size_extremes();
		test_output_stall();
		test_input_pause();
		test_random_frames();
		test_full_rate();
		wait_drained();
		if (filtered_queue.size() != 0) begin
			report_mismatch($sformatf("%0d result transactions never arrived",
				filtered_queue.size()));
		end
		if (errors == 0) begin
			$display("** laplacian_3x3_rgb_mirror: PASSED **");
		end else begin
			$display("** laplacian_3x3_rgb_mirror: FAILED **");
		end
		$finish;
	end

endmodule
